/* sv/tpc_pkg.sv */
// shared types and constants for the triangle point containment core
`default_nettype none

package tpc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A_X = 3'd0,
    REG_VERTEX_A_Y = 3'd1,
    REG_VERTEX_B_X = 3'd2,
    REG_VERTEX_B_Y = 3'd3,
    REG_VERTEX_C_X = 3'd4,
    REG_VERTEX_C_Y = 3'd5
  } tpc_reg_e;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_RECT  = 1'b1
  } tpc_op_e;

endpackage

`default_nettype wire

/* sv/tpc_edge.sv */
// edge function test of one triangle edge against up to four rectangle corners
`default_nettype none

module tpc_edge #(
  parameter int unsigned COORD_WIDTH = tpc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic signed [COORD_WIDTH-1:0] p1x_i,
  input  wire logic signed [COORD_WIDTH-1:0] p1y_i,
  input  wire logic signed [COORD_WIDTH-1:0] p2x_i,
  input  wire logic signed [COORD_WIDTH-1:0] p2y_i,
  input  wire logic signed [COORD_WIDTH-1:0] qx0_i,
  input  wire logic signed [COORD_WIDTH-1:0] qx1_i,
  input  wire logic signed [COORD_WIDTH-1:0] qy0_i,
  input  wire logic signed [COORD_WIDTH-1:0] qy1_i,
  // corner order: (x0,y0), (x0,y1), (x1,y0), (x1,y1)
  output logic             [3:0]             pass_o
);
  import tpc_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;
  localparam int unsigned SW = 2 * COORD_WIDTH + 3;

  logic signed [DW-1:0] ex, ey;
  logic signed [DW-1:0] vx [2];
  logic signed [DW-1:0] vy [2];
  logic signed [PW-1:0] pyx [2];
  logic signed [PW-1:0] pxx [2];
  logic signed [PW-1:0] pxy [2];
  logic signed [PW-1:0] pyy [2];

  assign ex    = DW'(p2x_i) - DW'(p1x_i);
  assign ey    = DW'(p2y_i) - DW'(p1y_i);
  assign vx[0] = DW'(qx0_i) - DW'(p1x_i);
  assign vx[1] = DW'(qx1_i) - DW'(p1x_i);
  assign vy[0] = DW'(qy0_i) - DW'(p1y_i);
  assign vy[1] = DW'(qy1_i) - DW'(p1y_i);

  // products are shared between the corners that have the same x or y
  for (genvar k = 0; k < 2; k++) begin : g_prod
    assign pyx[k] = PW'(ey) * PW'(vx[k]);
    assign pxx[k] = PW'(ex) * PW'(vx[k]);
    assign pxy[k] = PW'(ex) * PW'(vy[k]);
    assign pyy[k] = PW'(ey) * PW'(vy[k]);
  end

  for (genvar c = 0; c < 4; c++) begin : g_corner
    logic signed [SW-1:0] d, dot;
    assign d   = SW'(pyx[c/2]) - SW'(pxy[c%2]);
    assign dot = SW'(pxx[c/2]) + SW'(pyy[c%2]);
    // on the edge line the point passes only ahead of the start vertex
    assign pass_o[c] = (d == '0) ? (dot > 0) : d[SW-1];
  end

endmodule

`default_nettype wire

/* sv/triangle_point_containment_core.sv */
// top level of the triangle point containment core: config, stage registers, result
`default_nettype none

// Tests whether a point, or all four corners of a rectangle, lie inside the
// triangle A, B, C held in the vertex registers, using one edge function per
// edge with products kept at full width. Every item gives exactly one result
// in bit 0 of m_axis_tdata_o. One item is taken each cycle while the output
// is not stalled; an item passes an input register and then a result register,
// where its result is held on the output until it is taken.
// The edge units of AB, BC and CA with their shared corner multipliers set the
// critical path between those registers. A point on a start vertex and any
// edge of zero length count as outside. Vertex writes must only happen while no
// item is in flight.

module triangle_point_containment_core #(
  parameter int unsigned COORD_WIDTH = tpc_pkg::COORD_WIDTH_DEF,
  localparam int unsigned IN_W  = ((4 * COORD_WIDTH + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_W = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]          cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // operation, x_lo, y_lo, x_hi, y_hi (lowest bit up)
  input  wire logic [IN_W-1:0]                 s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // inside_res
  output logic [OUT_W-1:0]                     m_axis_tdata_o
);
  import tpc_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic signed [W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_we_i) begin
      case (tpc_reg_e'(cfg_idx_i))
        REG_VERTEX_A_X: ax_q <= cfg_data_i;
        REG_VERTEX_A_Y: ay_q <= cfg_data_i;
        REG_VERTEX_B_X: bx_q <= cfg_data_i;
        REG_VERTEX_B_Y: by_q <= cfg_data_i;
        REG_VERTEX_C_X: cx_q <= cfg_data_i;
        REG_VERTEX_C_Y: cy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic                in_valid_q;
  tpc_op_e             op_q;
  logic signed [W-1:0] xl_q, yl_q, xh_q, yh_q;
  logic                in_ready;

  // result stage
  logic out_valid_q;
  logic inside_q, inside_d;

  assign in_ready        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      op_q <= tpc_op_e'(s_axis_tdata_i[0]);
      xl_q <= s_axis_tdata_i[W:1];
      yl_q <= s_axis_tdata_i[2*W:W+1];
      xh_q <= s_axis_tdata_i[3*W:2*W+1];
      yh_q <= s_axis_tdata_i[4*W:3*W+1];
    end
  end

  logic [3:0] pass_ab, pass_bc, pass_ca, corner_in;

  tpc_edge #(.COORD_WIDTH(W)) u_edge_ab (
    .p1x_i(ax_q), .p1y_i(ay_q), .p2x_i(bx_q), .p2y_i(by_q),
    .qx0_i(xl_q), .qx1_i(xh_q), .qy0_i(yl_q), .qy1_i(yh_q),
    .pass_o(pass_ab)
  );

  tpc_edge #(.COORD_WIDTH(W)) u_edge_bc (
    .p1x_i(bx_q), .p1y_i(by_q), .p2x_i(cx_q), .p2y_i(cy_q),
    .qx0_i(xl_q), .qx1_i(xh_q), .qy0_i(yl_q), .qy1_i(yh_q),
    .pass_o(pass_bc)
  );

  tpc_edge #(.COORD_WIDTH(W)) u_edge_ca (
    .p1x_i(cx_q), .p1y_i(cy_q), .p2x_i(ax_q), .p2y_i(ay_q),
    .qx0_i(xl_q), .qx1_i(xh_q), .qy0_i(yl_q), .qy1_i(yh_q),
    .pass_o(pass_ca)
  );

  assign corner_in = pass_ab & pass_bc & pass_ca;

  always_comb begin
    case (op_q)
      OP_POINT: inside_d = corner_in[0];
      OP_RECT:  inside_d = &corner_in;
      default:  inside_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_q) begin
      inside_q <= inside_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W-1){1'b0}}, inside_q};

  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o
  ) else $error("input side stalled with an empty result register");

  a_stage_advance : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_ready) |=> out_valid_q
  ) else $error("item lost between input and result register");

  a_cfg_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == REG_VERTEX_A_X) |=> ax_q == $past(cfg_data_i)
  ) else $error("vertex register write not taken");

  a_degenerate_edge : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ax_q == bx_q && ay_q == by_q) |-> !inside_d
  ) else $error("zero length edge reported a point inside");

endmodule

`default_nettype wire
